FILE: hw/rtl/rrbc_pkg.sv
`default_nettype none

package rrbc_pkg;

	// Fixed field widths of the request and response transactions
	localparam int OP_W   = 2;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 32;

	// Request operation codes
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_FILL   = 2'd1;
	localparam logic [OP_W-1:0] OP_ABORT  = 2'd2;

	// Response kinds
	localparam logic [OP_W-1:0] KIND_DATA  = 2'd0;
	localparam logic [OP_W-1:0] KIND_FETCH = 2'd1;
	localparam logic [OP_W-1:0] KIND_ERROR = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/rrbc_ifs.sv
`default_nettype none

// Request channel: lookups, fill bytes and fill aborts
interface rrbc_req_if;
	logic                        valid;
	logic                        ready;
	logic [rrbc_pkg::OP_W-1:0]   operation;
	logic [rrbc_pkg::ADDR_W-1:0] address;
	logic [rrbc_pkg::BYTE_W-1:0] fill_data;

	modport source (output valid, operation, address, fill_data, input ready);
	modport sink   (input valid, operation, address, fill_data, output ready);
endinterface

// Response channel: returned bytes, fetch requests and fill errors
interface rrbc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rrbc_pkg::OP_W-1:0]   kind;
	logic [rrbc_pkg::BYTE_W-1:0] data_byte;
	logic [rrbc_pkg::ADDR_W-1:0] block_base;

	modport source (output valid, kind, data_byte, block_base, input ready);
	modport sink   (input valid, kind, data_byte, block_base, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rrbc_byte_ram.sv
`default_nettype none

// Simple dual-port byte memory, one write and one registered read per cycle
module rrbc_byte_ram #(
	parameter int DEPTH = 1280,
	parameter int AW    = 11
) (
	input  wire                         clk,
	input  wire                         wr_en,
	input  wire  [AW-1:0]               wr_addr,
	input  wire  [rrbc_pkg::BYTE_W-1:0] wr_data,
	input  wire                         rd_en,
	input  wire  [AW-1:0]               rd_addr,
	output logic [rrbc_pkg::BYTE_W-1:0] rd_data
);

	logic [rrbc_pkg::BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/round_robin_block_byte_cache.sv
// A response is registered: it shows in the cycle after its request is accepted.
// Throughput: one request per cycle while no response waits; the single byte memory
// takes one read and one fill write per cycle; a block fill takes BLOCK_BYTES fills.
// Reset (arst_n low, asynchronous): all slots invalid, tags and victim pointer zero,
// no fill in progress, response register empty. Block bytes are not cleared.
`default_nettype none

module round_robin_block_byte_cache #(
	parameter int BLOCK_BYTES = 256,
	parameter int NUM_SLOTS   = 5,
	parameter int ADDR_BITS   = 32
) (
	input  wire     clk,
	input  wire     arst_n,
	rrbc_req_if.sink   req,
	rrbc_rsp_if.source rsp
);

	localparam int OFF_BITS = $clog2(BLOCK_BYTES);
	localparam int TAG_W    = ADDR_BITS - OFF_BITS;
	localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int MEM_D    = NUM_SLOTS * BLOCK_BYTES;
	localparam int MEM_AW   = $clog2(MEM_D);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	// ------------------------------------------------------------------
	// Slot directory: tags and valid bits in flops, compared in parallel
	// ------------------------------------------------------------------
	logic [TAG_W-1:0]     tag_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	logic [SLOT_W-1:0]    victim_q;

	// Fill sequencer
	logic                 busy_q;
	logic [OFF_BITS-1:0]  fill_cnt_q;
	logic [OFF_BITS-1:0]  pend_off_q;
	logic [rrbc_pkg::BYTE_W-1:0] pend_byte_q;

	// Response register
	logic                        res_vld_s1;
	logic [rrbc_pkg::OP_W-1:0]   res_kind_s1;
	logic [rrbc_pkg::BYTE_W-1:0] res_byte_s1;
	logic [rrbc_pkg::ADDR_W-1:0] res_base_s1;
	logic                        res_mem_s1;

	logic                        acc;
	logic [ADDR_BITS-1:0]        addr_in;
	logic [TAG_W-1:0]            tag_in;
	logic [OFF_BITS-1:0]         off_in;
	logic [NUM_SLOTS-1:0]        hit_vec;
	logic                        hit;
	logic [SLOT_W-1:0]           hit_slot;
	logic [SLOT_W-1:0]           next_victim;
	logic                        fill_last;

	// Decoded actions for this cycle
	logic                        do_claim;
	logic                        do_fill;
	logic                        do_done;
	logic                        do_abort;
	logic                        rd_en;
	logic                        res_vld;
	logic [rrbc_pkg::OP_W-1:0]   res_kind;
	logic [rrbc_pkg::BYTE_W-1:0] res_byte;
	logic [rrbc_pkg::ADDR_W-1:0] res_base;
	logic                        res_mem;

	logic [rrbc_pkg::BYTE_W-1:0] ram_rdata;

	// Take a new request whenever the response register is free or draining
	assign req.ready = !res_vld_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;

	assign addr_in = req.address[ADDR_BITS-1:0];
	assign tag_in  = addr_in[ADDR_BITS-1:OFF_BITS];
	assign off_in  = addr_in[OFF_BITS-1:0];

	always_comb begin
		for (int s = 0; s < NUM_SLOTS; s++) begin
			hit_vec[s] = valid_q[s] && (tag_q[s] == tag_in);
		end
	end

	// Lowest matching slot wins
	always_comb begin
		hit_slot = '0;
		for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
			if (hit_vec[s]) begin
				hit_slot = SLOT_W'(s);
			end
		end
	end

	assign hit         = |hit_vec;
	assign next_victim = (victim_q == LAST_SLOT) ? '0 : victim_q + 1'b1;
	assign fill_last   = &fill_cnt_q;

	always_comb begin
		do_claim = 1'b0;
		do_fill  = 1'b0;
		do_done  = 1'b0;
		do_abort = 1'b0;
		rd_en    = 1'b0;
		res_vld  = 1'b0;
		res_kind = rrbc_pkg::KIND_DATA;
		res_byte = '0;
		res_base = '0;
		res_mem  = 1'b0;
		if (acc) begin
			unique case (req.operation)
				rrbc_pkg::OP_LOOKUP: begin
					if (hit) begin
						// Byte comes from the memory read issued now
						rd_en   = 1'b1;
						res_vld = 1'b1;
						res_mem = 1'b1;
					end else if (!busy_q) begin
						// Miss: claim the next slot and request its block
						do_claim = 1'b1;
						res_vld  = 1'b1;
						res_kind = rrbc_pkg::KIND_FETCH;
						res_base = rrbc_pkg::ADDR_W'({tag_in, {OFF_BITS{1'b0}}});
					end
					// A miss during a fill is dropped
				end
				rrbc_pkg::OP_FILL: begin
					if (busy_q) begin
						do_fill = 1'b1;
						if (fill_last) begin
							// Answer the pending byte; forward it if it is this one
							do_done  = 1'b1;
							res_vld  = 1'b1;
							res_byte = (pend_off_q == fill_cnt_q) ? req.fill_data
							                                      : pend_byte_q;
						end
					end
				end
				rrbc_pkg::OP_ABORT: begin
					if (busy_q) begin
						do_abort = 1'b1;
						res_vld  = 1'b1;
						res_kind = rrbc_pkg::KIND_ERROR;
					end
				end
				default: begin
					// Unused code: drop
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Directory and fill state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				tag_q[s] <= '0;
			end
			valid_q    <= '0;
			victim_q   <= '0;
			busy_q     <= 1'b0;
			fill_cnt_q <= '0;
			pend_off_q <= '0;
		end else begin
			if (do_claim) begin
				victim_q             <= next_victim;
				tag_q[next_victim]   <= tag_in;
				valid_q[next_victim] <= 1'b0;
				busy_q               <= 1'b1;
				fill_cnt_q           <= '0;
				pend_off_q           <= off_in;
			end
			if (do_fill && !do_done) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
			if (do_done) begin
				valid_q[victim_q] <= 1'b1;
				busy_q            <= 1'b0;
				fill_cnt_q        <= '0;
			end
			if (do_abort) begin
				valid_q[victim_q] <= 1'b0;
				busy_q            <= 1'b0;
				fill_cnt_q        <= '0;
			end
		end
	end

	// Capture the pending byte as it streams past
	always_ff @(posedge clk) begin
		if (do_fill && (fill_cnt_q == pend_off_q)) begin
			pend_byte_q <= req.fill_data;
		end
	end

	// ------------------------------------------------------------------
	// Block byte memory: fill writes into the victim slot, lookups read hits
	// ------------------------------------------------------------------
	rrbc_byte_ram #(
		.DEPTH (MEM_D),
		.AW    (MEM_AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (do_fill),
		.wr_addr (MEM_AW'({victim_q, fill_cnt_q})),
		.wr_data (req.fill_data),
		.rd_en   (rd_en),
		.rd_addr (MEM_AW'({hit_slot, off_in})),
		.rd_data (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Response register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s1 <= 1'b0;
		end else if (acc) begin
			res_vld_s1 <= res_vld;
		end else if (rsp.ready) begin
			res_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_kind_s1 <= res_kind;
			res_byte_s1 <= res_byte;
			res_base_s1 <= res_base;
			res_mem_s1  <= res_mem;
		end
	end

	assign rsp.valid      = res_vld_s1;
	assign rsp.kind       = res_kind_s1;
	assign rsp.data_byte  = res_mem_s1 ? ram_rdata : res_byte_s1;
	assign rsp.block_base = res_base_s1;

`ifndef ASSERT_OFF
	// Fill counter only moves while a fill is in progress
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (fill_cnt_q == '0))
		else $error("fill count nonzero while idle");

	// The slot under fill never reads as valid
	a_victim_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !valid_q[victim_q])
		else $error("slot under fill marked valid");

	// No two valid slots hold the same block
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("several slots match one address");

	// Completing a fill produces a response
	a_done_resp: assert property (@(posedge clk) disable iff (!arst_n)
		do_done |=> (rsp.valid && (rsp.kind == rrbc_pkg::KIND_DATA) && !busy_q))
		else $error("fill completion without data response");
`endif

endmodule

`default_nettype wire
